/* rtl/itoa_pkg.sv */
package itoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int BASE_W     = 6;
  localparam int CHAR_W     = 8;
  localparam int REM_W      = BASE_W;
  localparam int STEP_W     = $clog2(VALUE_BITS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int STACK_DEPTH = VALUE_BITS;

  localparam logic [BASE_W-1:0] BASE_MIN  = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX  = BASE_W'(36);
  localparam logic [BASE_W-1:0] RADIX_DEC = BASE_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [BASE_W-1:0]            base;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } itoa_state_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else if (b < BASE_MIN) begin
      r = BASE_MIN;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < REM_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
    end
    return c;
  endfunction

endpackage

/* rtl/integer_to_ascii_radix.sv */
// Converts one integer per request into ASCII characters, most significant first.
// Each digit comes from the bit-serial divider; the block takes no new request until the last
// character of the current one has left the stack for the output register. Characters flow
// one per cycle while the output does not stall.
// Synchronous active-low reset empties the block; no clearing pass is needed.
module integer_to_ascii_radix (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  itoa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output itoa_pkg::out_t out_data
);

  itoa_pkg::itoa_state_t state_r, state_nxt;

  logic                            neg_r;
  logic [itoa_pkg::BASE_W-1:0]     base_r;
  logic [itoa_pkg::CNT_W-1:0]      cnt_r;
  logic [itoa_pkg::CHAR_W-1:0]     stk_r [itoa_pkg::STACK_DEPTH];
  logic                            out_valid_r;
  itoa_pkg::out_t                  out_data_r;

  logic [itoa_pkg::BASE_W-1:0]     base_cl;
  logic                            in_neg;
  logic [itoa_pkg::VALUE_BITS-1:0] in_mag;

  logic                            div_start;
  logic                            div_done;
  logic [itoa_pkg::VALUE_BITS-1:0] div_dividend;
  logic [itoa_pkg::VALUE_BITS-1:0] div_quot;
  logic [itoa_pkg::REM_W-1:0]      div_rem;
  logic                            quot_nz;

  logic                            push;
  logic                            pop;
  logic [itoa_pkg::CHAR_W-1:0]     push_char;
  logic                            out_free;
  logic                            in_acc;

  always_comb begin
    base_cl = itoa_pkg::clamp_base(in_data.base);
    in_neg  = (base_cl == itoa_pkg::RADIX_DEC) && in_data.value[itoa_pkg::VALUE_BITS-1];
    in_mag  = in_neg ? (~in_data.value + itoa_pkg::VALUE_BITS'(1)) : in_data.value;
  end

  assign quot_nz      = |div_quot;
  assign out_free     = !out_valid_r || !out_stall;
  assign in_acc       = in_valid && !in_stall;
  assign div_dividend = (state_r == itoa_pkg::ST_IDLE) ? in_mag : div_quot;

  itoa_div_serial u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = itoa_pkg::ST_DIV;
        end
      end
      itoa_pkg::ST_DIV: begin
        if (div_done && !quot_nz) begin
          state_nxt = neg_r ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        state_nxt = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (pop && cnt_r == itoa_pkg::CNT_W'(1)) begin
          state_nxt = itoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    push_char = itoa_pkg::digit_char(div_rem);
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        div_start = in_valid;
      end
      itoa_pkg::ST_DIV: begin
        push      = div_done;
        div_start = div_done && quot_nz;
      end
      itoa_pkg::ST_SIGN: begin
        push      = 1'b1;
        push_char = itoa_pkg::CHAR_MINUS;
      end
      itoa_pkg::ST_EMIT: begin
        pop = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (push) begin
        cnt_r <= cnt_r + itoa_pkg::CNT_W'(1);
      end else if (pop) begin
        cnt_r <= cnt_r - itoa_pkg::CNT_W'(1);
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Digits arrive least significant first; the stack turns them around.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg_r  <= in_neg;
      base_r <= base_cl;
    end
    if (push) begin
      stk_r[0] <= push_char;
      for (int i = 1; i < itoa_pkg::STACK_DEPTH; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < itoa_pkg::STACK_DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
    if (pop) begin
      out_data_r.character <= stk_r[0];
      out_data_r.last      <= (cnt_r == itoa_pkg::CNT_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/itoa_div_serial.sv */
module itoa_div_serial (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [itoa_pkg::VALUE_BITS-1:0]   dividend,
  input  logic [itoa_pkg::BASE_W-1:0]       divisor,
  output logic                              done,
  output logic [itoa_pkg::VALUE_BITS-1:0]   quotient,
  output logic [itoa_pkg::REM_W-1:0]        remainder
);

  logic                            busy_r;
  logic                            done_r;
  logic [itoa_pkg::STEP_W-1:0]     step_r;
  logic [itoa_pkg::VALUE_BITS-1:0] q_r;
  logic [itoa_pkg::REM_W-1:0]      rem_r;

  logic [itoa_pkg::REM_W:0]        rem_sh;
  logic                            ge;
  logic [itoa_pkg::REM_W:0]        rem_sub;
  logic [itoa_pkg::REM_W-1:0]      rem_nxt;

  // Restoring division, one quotient bit per cycle from the top of q_r.
  always_comb begin
    rem_sh  = {rem_r, q_r[itoa_pkg::VALUE_BITS-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
    rem_nxt = ge ? rem_sub[itoa_pkg::REM_W-1:0] : rem_sh[itoa_pkg::REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= itoa_pkg::STEP_W'(itoa_pkg::VALUE_BITS - 1);
      end else if (busy_r) begin
        step_r <= step_r - itoa_pkg::STEP_W'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[itoa_pkg::VALUE_BITS-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

/* rtl/itoa_checker.sv */
module itoa_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input itoa_pkg::out_t out_data
);

  // A request occupies the block for at least one division.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("itoa: request accepted twice in a row");

  // Every character is a digit, a lower-case letter or a minus sign.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.character >= itoa_pkg::CHAR_ZERO && out_data.character <= itoa_pkg::CHAR_NINE) ||
      (out_data.character >= itoa_pkg::CHAR_A && out_data.character <= itoa_pkg::CHAR_Z) ||
      (out_data.character == itoa_pkg::CHAR_MINUS))
    else $error("itoa: illegal character");

  // A minus sign is always followed by at least one digit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.character == itoa_pkg::CHAR_MINUS |-> !out_data.last)
    else $error("itoa: minus sign marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("itoa: output valid dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("itoa: output changed while stalled");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned RANDOM_REQS    = 380;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned DEC_DIGITS     = 10;

  localparam logic signed [itoa_pkg::VALUE_BITS-1:0] VAL_MIN =
    {1'b1, {(itoa_pkg::VALUE_BITS-1){1'b0}}};
  localparam logic signed [itoa_pkg::VALUE_BITS-1:0] VAL_MAX = ~VAL_MIN;

  typedef struct {
    itoa_pkg::in_t req;
    int unsigned   gap;
    bit            drain;
  } req_item_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  itoa_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  itoa_pkg::out_t out_data;

  req_item_t      req_q[$];
  itoa_pkg::out_t char_q[$];
  int unsigned    idle_cycles = 0;
  int unsigned    stall_left = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    mismatches = 0;
  bit             calm_in = 1'b0;
  bit             calm_out = 1'b0;

  integer_to_ascii_radix i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Appends the characters one request should produce, most significant first.
  function automatic void spell_number(itoa_pkg::in_t req);
    logic [itoa_pkg::VALUE_BITS-1:0] mag;
    logic [itoa_pkg::BASE_W-1:0]     radix;
    logic [itoa_pkg::BASE_W-1:0]     dig;
    logic [itoa_pkg::CHAR_W-1:0]     rev[$];
    bit                              neg;
    itoa_pkg::out_t                  o;
    radix = req.base;
    if (radix > itoa_pkg::BASE_MAX) begin
      radix = itoa_pkg::BASE_MAX;
    end else if (radix < itoa_pkg::BASE_MIN) begin
      radix = itoa_pkg::BASE_MIN;
    end
    mag = req.value;
    neg = (radix == itoa_pkg::RADIX_DEC) && mag[itoa_pkg::VALUE_BITS-1];
    // Negating the most negative value leaves its pattern, which is the right magnitude.
    if (neg) begin
      mag = -mag;
    end
    do begin
      dig = itoa_pkg::BASE_W'(mag % radix);
      if (dig < DEC_DIGITS) begin
        rev.push_back(itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(dig));
      end else begin
        rev.push_back(itoa_pkg::CHAR_A + itoa_pkg::CHAR_W'(dig) -
                      itoa_pkg::CHAR_W'(DEC_DIGITS));
      end
      mag = mag / radix;
    end while (mag != 0);
    if (neg) begin
      rev.push_back(itoa_pkg::CHAR_MINUS);
    end
    for (int k = rev.size() - 1; k >= 0; k--) begin
      o.character = rev[k];
      o.last      = (k == 0);
      char_q.push_back(o);
    end
  endfunction

  task automatic add_req(input logic signed [itoa_pkg::VALUE_BITS-1:0] v,
                         input logic [itoa_pkg::BASE_W-1:0] b,
                         input bit drain);
    req_item_t it;
    if ($urandom_range(0, 15) == 0) begin
      calm_in = !calm_in;
    end
    it.req.value = v;
    it.req.base  = b;
    it.gap       = calm_in ? 0 : $urandom_range(0, 4);
    it.drain     = drain;
    req_q.push_back(it);
  endtask

  always @(posedge clk) begin : drive
    int unsigned waited;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      idle_cycles <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        spell_number(in_data);
      end
      waited = in_valid ? 0 : idle_cycles;
      // A drain request holds off until every character already owed has come out.
      if (req_q.size() != 0 && waited >= req_q[0].gap &&
          !(req_q[0].drain && char_q.size() != 0)) begin
        in_data     <= req_q[0].req;
        in_valid    <= 1'b1;
        idle_cycles <= 0;
        req_q.pop_front();
      end else begin
        in_valid    <= 1'b0;
        idle_cycles <= waited + 1;
      end
    end
  end

  always @(posedge clk) begin : sink
    itoa_pkg::out_t want;
    int unsigned    hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (char_q.size() == 0) begin
        $error("unexpected result: character %h, last %b", out_data.character, out_data.last);
        mismatches++;
      end else begin
        want = char_q.pop_front();
        if (out_data.character !== want.character) begin
          $error("character: expected %h, actual %h", want.character, out_data.character);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_data.last);
          mismatches++;
        end
      end
      if ($urandom_range(0, 15) == 0) begin
        calm_out = !calm_out;
      end
      hold = calm_out ? 0 : $urandom_range(0, 4);
      out_stall  <= (hold != 0);
      stall_left <= hold;
    end else if (out_stall) begin
      if (stall_left <= 1) begin
        out_stall <= 1'b0;
      end
      stall_left <= stall_left - 1;
    end else if (!out_valid && !calm_out && $urandom_range(0, 31) == 0) begin
      // Stall now and then while no character is valid, so the first character can meet a stall.
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 4);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[integer_to_ascii_radix] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic signed [itoa_pkg::VALUE_BITS-1:0] v;
    logic [itoa_pkg::BASE_W-1:0]            b;

    add_req('0, itoa_pkg::RADIX_DEC, 1'b0);
    add_req('0, itoa_pkg::BASE_MIN, 1'b0);
    add_req(VAL_MAX, itoa_pkg::RADIX_DEC, 1'b0);
    add_req(VAL_MIN, itoa_pkg::RADIX_DEC, 1'b0);
    add_req(-1, itoa_pkg::RADIX_DEC, 1'b0);
    add_req(-1, itoa_pkg::BASE_MIN, 1'b0);
    add_req(VAL_MIN, itoa_pkg::BASE_MIN, 1'b0);
    add_req(VAL_MAX, itoa_pkg::BASE_MAX, 1'b0);
    add_req(-1, itoa_pkg::BASE_MAX, 1'b1);
    add_req(VAL_MIN, 16, 1'b0);
    add_req(35, itoa_pkg::BASE_MAX, 1'b0);
    add_req(9, itoa_pkg::RADIX_DEC, 1'b0);
    add_req(10, 16, 1'b0);
    add_req(255, 16, 1'b0);
    add_req(-42, 8, 1'b0);
    add_req(123456789, 7, 1'b0);
    add_req(1, 3, 1'b0);
    // Radix values outside 2..36 saturate.
    add_req(5, 0, 1'b0);
    add_req(5, 1, 1'b0);
    add_req(1295, itoa_pkg::BASE_W'(itoa_pkg::BASE_MAX + 1), 1'b0);
    add_req(-1295, 63, 1'b0);
    add_req(-7, 42, 1'b0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = $urandom;
        4: v = $urandom_range(0, 999);
        5: v = 0 - $urandom_range(1, 999);
        6: v = $urandom >> $urandom_range(0, itoa_pkg::VALUE_BITS - 1);
        7: begin
          v = $urandom;
          v = v >>> $urandom_range(0, itoa_pkg::VALUE_BITS - 1);
        end
        8: v = (itoa_pkg::VALUE_BITS'(1) << $urandom_range(0, itoa_pkg::VALUE_BITS - 1)) -
                $urandom_range(0, 1);
        default: begin
          case ($urandom_range(0, 3))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = -1;
            default: v = '0;
          endcase
        end
      endcase
      case ($urandom_range(0, 19))
        0: b = ($urandom_range(0, 3) == 0) ?
               itoa_pkg::BASE_W'($urandom_range(0, 1)) :
               itoa_pkg::BASE_W'($urandom_range(itoa_pkg::BASE_MAX + 1, 63));
        1, 2: b = itoa_pkg::RADIX_DEC;
        3: b = itoa_pkg::BASE_MIN;
        default: b = itoa_pkg::BASE_W'($urandom_range(itoa_pkg::BASE_MIN, itoa_pkg::BASE_MAX));
      endcase
      add_req(v, b, $urandom_range(0, 39) == 0);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sample on the falling edge so every update of the rising edge has settled.
    do begin
      @(negedge clk);
    end while (req_q.size() != 0 || in_valid || char_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[integer_to_ascii_radix] OK");
    end else begin
      $display("[integer_to_ascii_radix] ERROR");
    end
    $finish;
  end

endmodule
